// ===== rtl/war_pkg.sv =====
package war_pkg;

    // Price and average widths
    localparam int PRICE_W     = 32;
    localparam int FIELD_W     = 32;
    localparam int OUT_W       = 32;
    localparam int AVG_FRAC    = 16;
    localparam int AVG_W       = PRICE_W + AVG_FRAC;
    localparam int RATIO_SHIFT = 8;

    // Period and bar counter widths
    localparam int PERIOD_W = 8;
    localparam int BARS_W   = PERIOD_W + 1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

    // The smoothing numerator is avg * (period - 1) + tr, below 2^(AVG_W + PERIOD_W).
    localparam int NUM_W = AVG_W + PERIOD_W;

    // Divider shift register and step counter
    localparam int Q_W        = AVG_W + RATIO_SHIFT;
    localparam int STEP_CNT_W = $clog2(Q_W + 1);
    localparam logic [STEP_CNT_W-1:0] AVG_STEPS   = STEP_CNT_W'(AVG_W);
    localparam logic [STEP_CNT_W-1:0] RATIO_STEPS = STEP_CNT_W'(Q_W);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic first_load;
        logic tr_load;
        logic num_load;
        logic avg_start;
        logic avg_store;
        logic ratio_start;
        logic ratio_zero;
        logic ratio_store;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic first_bar;
        logic close_zero;
        logic div_done;
    } dp_stat_t;

    // Fit a bus price field to the internal price width.
    function automatic logic [PRICE_W-1:0] to_price(input logic [FIELD_W-1:0] x);
        return PRICE_W'(x);
    endfunction

endpackage

// ===== rtl/war_divider.sv =====
module war_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [war_pkg::PRICE_W-1:0]     rem_init,
    input  logic [war_pkg::Q_W-1:0]         q_init,
    input  logic [war_pkg::PRICE_W-1:0]     divisor,
    input  logic [war_pkg::STEP_CNT_W-1:0]  steps,
    output logic [war_pkg::Q_W-1:0]         quotient,
    output logic                            done
);
    import war_pkg::*;

    logic [PRICE_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]        q_reg, q_next;
    logic [PRICE_W-1:0]    div_reg, div_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PRICE_W:0]      trial;
    logic                  fits;

    // One restoring step: bring down the next numerator bit and try the subtract.
    assign trial = {rem_reg, q_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = rem_init;
            q_next    = q_init;
            div_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? PRICE_W'(trial - {1'b0, div_reg}) : trial[PRICE_W-1:0];
            q_next   = {q_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/war_datapath.sv =====
module war_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  war_pkg::dp_cmd_t                cmd,
    output war_pkg::dp_stat_t               stat,
    input  logic [3*war_pkg::FIELD_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            cfg_valid,
    input  logic [war_pkg::PERIOD_W-1:0]    cfg_data,
    output logic [2*war_pkg::OUT_W-1:0]     m_tdata
);
    import war_pkg::*;

    // Configuration and series state
    logic [PERIOD_W-1:0] period_reg;
    logic [PRICE_W-1:0]  prior_close_reg;
    logic [BARS_W-1:0]   bars_reg;
    logic [AVG_W-1:0]    avg_reg;

    // Captured bar
    logic [PRICE_W-1:0]  high_reg, low_reg, close_reg;
    logic                restart_reg;

    // Intermediate values
    logic [PRICE_W-1:0]  tr_reg, tr_next;
    logic [PERIOD_W-1:0] mult_reg, mult_next;
    logic [PERIOD_W-1:0] dv_reg, dv_next;
    logic [BARS_W-1:0]   bars_next;
    logic [NUM_W-1:0]    num_reg;
    logic [OUT_W-1:0]    avg_res_reg, ratio_res_reg;
    logic [2*OUT_W-1:0]  out_reg;

    logic [PRICE_W-1:0]  hl, dh, dl;
    logic [PERIOD_W-1:0] p_eff;
    logic [BARS_W-1:0]   p_plus1, bs;
    logic [63:0]         avg_wide;
    logic [OUT_W-1:0]    avg_sat;

    // Divider hookup
    logic                  div_start;
    logic [PRICE_W-1:0]    div_rem_init;
    logic [Q_W-1:0]        div_q_init;
    logic [PRICE_W-1:0]    div_divisor;
    logic [STEP_CNT_W-1:0] div_steps;
    logic [Q_W-1:0]        div_quot;
    logic                  div_done;

    // True range: the largest of the bar span and both gaps to the prior close.
    always_comb begin
        hl = (high_reg >= low_reg) ? high_reg - low_reg : '0;
        dh = (high_reg >= prior_close_reg) ? high_reg - prior_close_reg
                                           : prior_close_reg - high_reg;
        dl = (low_reg >= prior_close_reg) ? low_reg - prior_close_reg
                                          : prior_close_reg - low_reg;
        tr_next = hl;
        if (dh > tr_next) tr_next = dh;
        if (dl > tr_next) tr_next = dl;
    end

    // Warm-up mean or Wilder smoothing, chosen from the clamped bar count.
    always_comb begin
        p_eff   = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        p_plus1 = {1'b0, p_eff} + BARS_W'(1);
        bs      = (bars_reg > p_plus1) ? p_plus1 : bars_reg;
        if (bs <= {1'b0, p_eff}) begin
            mult_next = bs[PERIOD_W-1:0] - PERIOD_W'(1);
            dv_next   = bs[PERIOD_W-1:0];
        end else begin
            mult_next = p_eff - PERIOD_W'(1);
            dv_next   = p_eff;
        end
        bars_next = (bs == p_plus1) ? p_plus1 : bs + BARS_W'(1);
    end

    // The new average leaves the divider; its field saturates when the price
    // width exceeds the output width.
    assign avg_wide = 64'(div_quot[AVG_W-1:AVG_FRAC]);
    assign avg_sat  = (avg_wide > 64'(OUT_MAX)) ? OUT_MAX : avg_wide[OUT_W-1:0];

    // Divider operands: the smoothing division preloads the top numerator bits,
    // which are known to be below the divisor.
    always_comb begin
        div_start = cmd.avg_start | cmd.ratio_start;
        if (cmd.avg_start) begin
            div_rem_init = PRICE_W'(num_reg[NUM_W-1:AVG_W]);
            div_q_init   = {num_reg[AVG_W-1:0], {(Q_W-AVG_W){1'b0}}};
            div_divisor  = PRICE_W'(dv_reg);
            div_steps    = AVG_STEPS;
        end else begin
            div_rem_init = '0;
            div_q_init   = {avg_reg, {RATIO_SHIFT{1'b0}}};
            div_divisor  = close_reg;
            div_steps    = RATIO_STEPS;
        end
    end

    war_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .q_init   (div_q_init),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quot),
        .done     (div_done)
    );

    // State that reset defines.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= PERIOD_RESET;
            prior_close_reg <= '0;
            bars_reg        <= '0;
            avg_reg         <= '0;
        end else begin
            if (cfg_valid) period_reg <= cfg_data;
            if (cmd.first_load) begin
                prior_close_reg <= close_reg;
                bars_reg        <= BARS_W'(1);
                avg_reg         <= '0;
            end
            if (cmd.tr_load) begin
                prior_close_reg <= close_reg;
                bars_reg        <= bars_next;
            end
            if (cmd.avg_store) avg_reg <= div_quot[AVG_W-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            high_reg    <= to_price(s_tdata[FIELD_W-1:0]);
            low_reg     <= to_price(s_tdata[2*FIELD_W-1:FIELD_W]);
            close_reg   <= to_price(s_tdata[3*FIELD_W-1:2*FIELD_W]);
            restart_reg <= s_tuser[0];
        end
        if (cmd.tr_load) begin
            tr_reg   <= tr_next;
            mult_reg <= mult_next;
            dv_reg   <= dv_next;
        end
        if (cmd.num_load) begin
            num_reg <= NUM_W'(avg_reg) * NUM_W'(mult_reg)
                     + NUM_W'({tr_reg, {AVG_FRAC{1'b0}}});
        end
        if (cmd.first_load) begin
            avg_res_reg   <= '0;
            ratio_res_reg <= '0;
        end
        if (cmd.avg_store) avg_res_reg <= avg_sat;
        if (cmd.ratio_zero) ratio_res_reg <= '0;
        if (cmd.ratio_store) begin
            ratio_res_reg <= (div_quot[Q_W-1:OUT_W] != '0) ? OUT_MAX : div_quot[OUT_W-1:0];
        end
        if (cmd.out_load) out_reg <= {ratio_res_reg, avg_res_reg};
    end

    assign stat.first_bar  = restart_reg | (bars_reg == '0);
    assign stat.close_zero = (close_reg == '0);
    assign stat.div_done   = div_done;
    assign m_tdata         = out_reg;

endmodule

// ===== rtl/war_ctrl.sv =====
module war_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output war_pkg::dp_cmd_t  cmd,
    input  war_pkg::dp_stat_t stat
);
    import war_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_TR        = 3'd1;
    localparam logic [2:0] S_MUL       = 3'd2;
    localparam logic [2:0] S_AVG_GO    = 3'd3;
    localparam logic [2:0] S_AVG_RUN   = 3'd4;
    localparam logic [2:0] S_RATIO_GO  = 3'd5;
    localparam logic [2:0] S_RATIO_RUN = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;

    // The output slot can take a new word once the held one is gone or leaving.
    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_TR;
            end
            S_TR: begin
                if (stat.first_bar) begin
                    cmd.first_load = 1'b1;
                    state_next     = S_FINISH;
                end else begin
                    cmd.tr_load = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.num_load = 1'b1;
                state_next   = S_AVG_GO;
            end
            S_AVG_GO: begin
                cmd.avg_start = 1'b1;
                state_next    = S_AVG_RUN;
            end
            S_AVG_RUN: begin
                if (stat.div_done) begin
                    cmd.avg_store = 1'b1;
                    state_next    = S_RATIO_GO;
                end
            end
            S_RATIO_GO: begin
                if (stat.close_zero) begin
                    cmd.ratio_zero = 1'b1;
                    state_next     = S_FINISH;
                end else begin
                    cmd.ratio_start = 1'b1;
                    state_next      = S_RATIO_RUN;
                end
            end
            S_RATIO_RUN: begin
                if (stat.div_done) begin
                    cmd.ratio_store = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/wilder_atr_ratio.sv =====
// An accepted bar yields its result word after the smoothing and ratio divisions, after
// the smoothing alone when the close is zero and with no division for the first bar of a
// series, plus any wait for the output slot. A new bar is accepted only once the previous
// one has entered the output slot; the shared divider retires one quotient bit per cycle,
// 48 bits for the smoothing step and 56 for the ratio.
// Reset: synchronous, active low; period returns to 14 and the series history is cleared.
module wilder_atr_ratio (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: bar_high[31:0], bar_low[63:32], bar_close[95:64].
    input  logic [3*war_pkg::FIELD_W-1:0]      s_tdata,
    // Fields from bit 0: restart[0].
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: avg_range[31:0], range_ratio[63:32].
    output logic [2*war_pkg::OUT_W-1:0]        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [war_pkg::PERIOD_W-1:0]       cfg_data
);
    import war_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The period register is always ready; the user must write it only while idle, as the block does not enforce this.
    assign cfg_ready = 1'b1;

    war_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    war_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/war_checker.sv =====
module war_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [2*war_pkg::OUT_W-1:0]        m_tdata
);
    logic s_acc, m_acc;
    logic [1:0] pend_reg;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Words accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One bar at a time: input closes right after an accept.
    a_one_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("input ready right after an accepted bar");

    // Every result word comes from an accepted bar.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result word without an accepted bar");

    // At most one bar in work and one result waiting.
    a_pend_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many bars outstanding");

    // Reset empties the output.
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wilder_atr_ratio war_checker u_war_checker (.*);
